// File: hw/rtl/pip_pkg.sv
// Package for the point-in-polygon block: sizes, codes, beat and vertex types.
// No dependencies; imported by every module in hw/rtl.
package pip_pkg;

   localparam int MAX_VERTICES   = 16;
   localparam int COORD_WIDTH    = 32;
   localparam int MIN_POLY_VERTS = 3;

   localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int HELD_W  = 5;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic [1:0]                    action;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic              inside_res;
      logic [1:0]        status;
      logic [HELD_W-1:0] vertices_held;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } edge_ctl_type;

endpackage

// File: hw/rtl/pip_cell.sv
// One vertex cell of the rotating vertex chain.
// Depends on pip_pkg.
module pip_cell (
   input  logic                clock,
   input  logic                load,
   input  logic                shift,
   input  pip_pkg::vertex_type din,
   input  pip_pkg::vertex_type nbr,
   output pip_pkg::vertex_type q
);
   import pip_pkg::*;

   vertex_type v_ff;
   vertex_type v_in;

   always_comb begin
      priority if (load) begin
         v_in = din;
      end else if (shift) begin
         v_in = nbr;
      end else begin
         v_in = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   assign q = v_ff;

endmodule

// File: hw/rtl/pip_edge_unit.sv
// Edge crossing evaluator: difference stage, multiply stage, compare and parity.
// Depends on pip_pkg.
module pip_edge_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  pip_pkg::edge_ctl_type ctl,
   input  pip_pkg::vertex_type   cur,
   input  pip_pkg::vertex_type   prev,
   input  pip_pkg::vertex_type   point,
   output logic                  parity
);
   import pip_pkg::*;

   localparam int CM = COORD_WIDTH - 1;

   logic                     va_ff, va_in;
   logic                     sa_ff, sa_in;
   logic signed [DIFF_W-1:0] dy_ff, dy_in;
   logic signed [DIFF_W-1:0] a_ff, a_in;
   logic signed [DIFF_W-1:0] b_ff, b_in;
   logic signed [DIFF_W-1:0] c_ff, c_in;

   logic                     vb_ff, vb_in;
   logic                     sb_ff, sb_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] p1_ff, p1_in;
   logic signed [PROD_W-1:0] p2_ff, p2_in;

   logic                     par_ff, par_in;
   logic                     hit;

   always_comb begin
      va_in = ctl.valid;
      sa_in = (cur.y > point.y) != (prev.y > point.y);
      dy_in = {prev.y[CM], prev.y} - {cur.y[CM], cur.y};
      a_in  = {point.x[CM], point.x} - {cur.x[CM], cur.x};
      b_in  = {prev.x[CM], prev.x} - {cur.x[CM], cur.x};
      c_in  = {point.y[CM], point.y} - {cur.y[CM], cur.y};

      vb_in  = va_ff;
      sb_in  = sa_ff;
      neg_in = dy_ff[DIFF_W-1];
      p1_in  = a_ff * dy_ff;
      p2_in  = b_ff * c_ff;

      hit = neg_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff);
      priority if (ctl.clear) begin
         par_in = 1'b0;
      end else if (vb_ff && sb_ff && hit) begin
         par_in = !par_ff;
      end else begin
         par_in = par_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         par_ff <= 1'b0;
      end else begin
         va_ff  <= va_in;
         vb_ff  <= vb_in;
         par_ff <= par_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff  <= sa_in;
      dy_ff  <= dy_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      sb_ff  <= sb_in;
      neg_ff <= neg_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
   end

   assign parity = par_ff;

endmodule

// File: hw/rtl/point_in_polygon_test.sv
// Point-in-polygon top level: control, bounds, vertex cell chain, edge evaluator.
// Depends on pip_pkg, pip_cell and pip_edge_unit.
//
// Clear, append, action three and a query that is rejected (zone disabled, fewer than
// three vertices, or point outside the bounding box) answer in the cycle after the start
// beat and leave busy low. A query that is evaluated holds busy high while the first
// vertex is captured, then the vertex chain rotates once through all of its cells, one
// edge a cycle into a single evaluator with two multipliers, and then that evaluator
// is drained. Its result comes in the cycle busy falls. Each result is shown for one
// cycle with rsp_valid; the receiver cannot stall it. csr_ready is always high. The
// vertex cells need no clearing after reset.
module point_in_polygon_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pip_pkg::req_type req_data,
   output logic             rsp_valid,
   output pip_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import pip_pkg::*;

   localparam logic [COUNT_W-1:0] CNT_FULL = COUNT_W'(MAX_VERTICES);
   localparam logic [COUNT_W-1:0] CNT_MIN  = COUNT_W'(MIN_POLY_VERTS);

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] t_ff, t_in;
   logic [1:0] fl_ff, fl_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic signed [COORD_WIDTH-1:0] minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [COORD_WIDTH-1:0] miny_ff, miny_in, maxy_ff, maxy_in;
   logic zone_ff, zone_in;
   vertex_type first_ff, first_in;
   vertex_type prev_ff, prev_in;
   vertex_type point_ff, point_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic poly_ok;
   logic in_box;
   logic run_go;
   logic append_ok;
   logic rotate;
   logic parity;
   edge_ctl_type edge_ctl;
   vertex_type cur;
   vertex_type din;
   vertex_type chain_q [MAX_VERTICES];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign poly_ok   = zone_ff && (count_ff >= CNT_MIN);
   assign in_box    = !(req_data.coord_x < minx_ff || req_data.coord_x > maxx_ff ||
                        req_data.coord_y < miny_ff || req_data.coord_y > maxy_ff);
   assign run_go    = accept && (req_data.action == ACT_QUERY) && poly_ok && in_box;
   assign append_ok = accept && (req_data.action == ACT_APPEND) && (count_ff != CNT_FULL);
   assign din       = '{x: req_data.coord_x, y: req_data.coord_y};

   genvar k;
   generate
      for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
         pip_cell u_cell (
            .clock (clock),
            .load  (append_ok && (count_ff == COUNT_W'(k))),
            .shift (rotate),
            .din   (din),
            .nbr   (chain_q[(k + 1) % MAX_VERTICES]),
            .q     (chain_q[k])
         );
      end
   endgenerate

   pip_edge_unit u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (edge_ctl),
      .cur    (cur),
      .prev   (prev_ff),
      .point  (point_ff),
      .parity (parity)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_go) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (t_ff == CNT_FULL) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (fl_ff == 2'd2) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      t_in         = '0;
      fl_in        = '0;
      count_in     = count_ff;
      minx_in      = minx_ff;
      maxx_in      = maxx_ff;
      miny_in      = miny_ff;
      maxy_in      = maxy_ff;
      zone_in      = (csr_valid && csr_ready) ? csr_data : zone_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      point_in     = point_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rotate       = 1'b0;
      edge_ctl     = '{clear: run_go, valid: 1'b0};
      cur          = (t_ff == count_ff) ? first_ff : chain_q[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.inside_res = 1'b0;
               rsp_in.status     = STAT_OK;
               point_in          = din;
               unique case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     minx_in  = COORD_MAX;
                     miny_in  = COORD_MAX;
                     maxx_in  = COORD_MIN;
                     maxy_in  = COORD_MIN;
                  end
                  ACT_APPEND: begin
                     if (append_ok) begin
                        count_in = count_ff + 1'b1;
                        if (req_data.coord_x < minx_ff) minx_in = req_data.coord_x;
                        if (req_data.coord_x > maxx_ff) maxx_in = req_data.coord_x;
                        if (req_data.coord_y < miny_ff) miny_in = req_data.coord_y;
                        if (req_data.coord_y > maxy_ff) maxy_in = req_data.coord_y;
                     end else begin
                        rsp_in.status = STAT_FULL;
                     end
                  end
                  ACT_QUERY: begin
                     if (!poly_ok) rsp_in.status = STAT_INVALID;
                  end
                  default: begin
                  end
               endcase
               rsp_in.vertices_held = HELD_W'(count_in);
               rsp_valid_in         = !run_go;
            end
         end
         ST_RUN: begin
            t_in           = t_ff + 1'b1;
            rotate         = (t_ff != CNT_FULL);
            prev_in        = chain_q[0];
            edge_ctl.valid = (t_ff != '0) && (t_ff <= count_ff);
            if (t_ff == '0) first_in = chain_q[0];
         end
         ST_FLUSH: begin
            fl_in = fl_ff + 1'b1;
            if (fl_ff == 2'd2) begin
               rsp_in.inside_res    = parity;
               rsp_in.status        = STAT_OK;
               rsp_in.vertices_held = HELD_W'(count_ff);
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         t_ff         <= '0;
         fl_ff        <= '0;
         count_ff     <= '0;
         minx_ff      <= COORD_MAX;
         miny_ff      <= COORD_MAX;
         maxx_ff      <= COORD_MIN;
         maxy_ff      <= COORD_MIN;
         zone_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         fl_ff        <= fl_in;
         count_ff     <= count_in;
         minx_ff      <= minx_in;
         miny_ff      <= miny_in;
         maxx_ff      <= maxx_in;
         maxy_ff      <= maxy_in;
         zone_ff      <= zone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      prev_ff  <= prev_in;
      point_ff <= point_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action != ACT_QUERY) |=> rsp_valid)
      else $error("missing result beat after non-query item");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("vertex count beyond store depth");

   a_run_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !rsp_valid_ff)
      else $error("result beat during edge walk");

endmodule

// File: test/tb.sv
// Testbench for point_in_polygon_test: clear/append/query beats with random gaps,
// checked against an in-bench even-odd crossing predictor. Depends on pip_pkg and the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LIMIT_CYCLES  = 300000;

   typedef enum logic [1:0] {
      OP_COMMAND,
      OP_ZONE_WRITE,
      OP_SETTLE
   } op_kind_type;

   typedef struct {
      op_kind_type kind;
      req_type     req;
      logic        zone;
      int          idle_pct;
   } pending_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   pending_op_type pending_ops[$];
   rsp_type        answer_queue[$];
   longint         shape_x[$];
   longint         shape_y[$];

   int sender_idle_pct = 32;
   int items_made      = 0;
   int settle_count    = 0;
   int cycle_count     = 0;
   int errors          = 0;
   int answers_checked = 0;
   int inside_seen     = 0;
   int full_seen       = 0;
   int invalid_seen    = 0;
   int zone_writes     = 0;

   // predictor state
   logic signed [COORD_WIDTH-1:0] poly_x[MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] poly_y[MAX_VERTICES];
   int                            held;
   logic signed [COORD_WIDTH-1:0] box_min_x, box_min_y, box_max_x, box_max_y;
   logic                          zone_on;

   point_in_polygon_test DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic void empty_polygon();
      held      = 0;
      box_min_x = COORD_MAX;
      box_min_y = COORD_MAX;
      box_max_x = COORD_MIN;
      box_max_y = COORD_MIN;
   endfunction

   function automatic logic crossing_odd(logic signed [COORD_WIDTH-1:0] px,
                                         logic signed [COORD_WIDTH-1:0] py);
      logic              odd;
      int                i, j;
      logic signed [71:0] qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
      odd = 1'b0;
      if (px < box_min_x || px > box_max_x || py < box_min_y || py > box_max_y)
         return 1'b0;
      qx = px;
      qy = py;
      j = held - 1;
      for (i = 0; i < held; i++) begin
         if ((poly_y[i] > py) != (poly_y[j] > py)) begin
            xi  = poly_x[i];
            yi  = poly_y[i];
            xj  = poly_x[j];
            yj  = poly_y[j];
            dy  = yj - yi;
            lhs = (qx - xi) * dy;
            rhs = (xj - xi) * (qy - yi);
            if (dy > 0 ? lhs < rhs : lhs > rhs) odd = ~odd;
         end
         j = i;
      end
      return odd;
   endfunction

   function automatic rsp_type predict_answer(req_type r);
      rsp_type a;
      a = '0;
      case (r.action)
         ACT_CLEAR: empty_polygon();
         ACT_APPEND: begin
            if (held >= MAX_VERTICES) begin
               a.status = STAT_FULL;
            end else begin
               poly_x[held] = r.coord_x;
               poly_y[held] = r.coord_y;
               held++;
               if (r.coord_x < box_min_x) box_min_x = r.coord_x;
               if (r.coord_x > box_max_x) box_max_x = r.coord_x;
               if (r.coord_y < box_min_y) box_min_y = r.coord_y;
               if (r.coord_y > box_max_y) box_max_y = r.coord_y;
            end
         end
         ACT_QUERY: begin
            if (!zone_on || held < MIN_POLY_VERTS) a.status = STAT_INVALID;
            else a.inside_res = crossing_odd(r.coord_x, r.coord_y);
         end
         default: ;
      endcase
      a.vertices_held = HELD_W'(held);
      return a;
   endfunction

   // monitor: check the result beat first, then predict for the beat accepted now
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         empty_polygon();
         zone_on = 1'b1;
      end else begin
         if (rsp_valid) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected answer inside=%0d status=%0d held=%0d", $time,
                        rsp_data.inside_res, rsp_data.status, rsp_data.vertices_held);
               errors++;
            end else begin
               want = answer_queue.pop_front();
               answers_checked++;
               if (rsp_data.inside_res != want.inside_res || rsp_data.status != want.status
                   || rsp_data.vertices_held != want.vertices_held) begin
                  $display("%0t: answer mismatch: expected inside=%0d status=%0d held=%0d, ",
                           $time, want.inside_res, want.status, want.vertices_held,
                           "got inside=%0d status=%0d held=%0d",
                           rsp_data.inside_res, rsp_data.status, rsp_data.vertices_held);
                  errors++;
               end
               if (want.inside_res) inside_seen++;
               if (want.status == STAT_FULL) full_seen++;
               if (want.status == STAT_INVALID) invalid_seen++;
            end
         end
         if (start && !busy) answer_queue = {answer_queue, predict_answer(req_data)};
         if (csr_valid && csr_ready) begin
            zone_on = csr_data;
            zone_writes++;
         end
      end
   end

   // driver
   always @(posedge clock) begin
      logic nxt_start, nxt_csr, quiet;
      if (reset) begin
         start        <= 1'b0;
         csr_valid    <= 1'b0;
         settle_count <= 0;
      end else begin
         nxt_start = start;
         nxt_csr   = csr_valid;
         if (start && !busy) begin
            void'(pending_ops.pop_front());
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            void'(pending_ops.pop_front());
            nxt_csr = 1'b0;
         end
         quiet = answer_queue.size() == 0 && !busy && !rsp_valid && !nxt_start && !nxt_csr;
         settle_count <= quiet ? settle_count + 1 : 0;
         if (!nxt_start && !nxt_csr && pending_ops.size() != 0) begin
            case (pending_ops[0].kind)
               OP_COMMAND: begin
                  if ($urandom_range(99) >= pending_ops[0].idle_pct) begin
                     req_data  <= pending_ops[0].req;
                     nxt_start = 1'b1;
                  end
               end
               OP_ZONE_WRITE: begin
                  if (settle_count >= SETTLE_CYCLES) begin
                     csr_data <= pending_ops[0].zone;
                     nxt_csr  = 1'b1;
                  end
               end
               default: begin
                  if (settle_count >= SETTLE_CYCLES) void'(pending_ops.pop_front());
               end
            endcase
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   function automatic longint rand_span(longint lo, longint hi);
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return lo + longint'(r % 64'(hi - lo + 1));
   endfunction

   function automatic void add_item(logic [1:0] act, longint x, longint y);
      pending_op_type op;
      longint         sx, sy;
      op.kind        = OP_COMMAND;
      op.req.action  = act;
      op.req.coord_x = x[31:0];
      op.req.coord_y = y[31:0];
      op.zone        = 1'b0;
      op.idle_pct    = sender_idle_pct;
      pending_ops    = {pending_ops, op};
      items_made++;
      if (act == ACT_CLEAR) begin
         shape_x.delete();
         shape_y.delete();
      end else if (act == ACT_APPEND && shape_x.size() < MAX_VERTICES) begin
         sx = x[31:0] >= 32'h8000_0000 ? longint'(x[31:0]) - 64'sh1_0000_0000
                                        : longint'(x[31:0]);
         sy = y[31:0] >= 32'h8000_0000 ? longint'(y[31:0]) - 64'sh1_0000_0000
                                        : longint'(y[31:0]);
         shape_x = {shape_x, sx};
         shape_y = {shape_y, sy};
      end
   endfunction

   function automatic void add_control(op_kind_type kind, logic zone);
      pending_op_type op;
      op.kind     = kind;
      op.req      = '0;
      op.zone     = zone;
      op.idle_pct = 0;
      pending_ops = {pending_ops, op};
   endfunction

   function automatic void add_probe();
      longint bx0, bx1, by0, by1, px, py;
      int     k, m;
      if (shape_x.size() == 0) begin
         add_item(ACT_QUERY, rand_span(COORD_MIN, COORD_MAX), rand_span(COORD_MIN, COORD_MAX));
         return;
      end
      bx0 = shape_x[0]; bx1 = shape_x[0]; by0 = shape_y[0]; by1 = shape_y[0];
      foreach (shape_x[n]) begin
         if (shape_x[n] < bx0) bx0 = shape_x[n];
         if (shape_x[n] > bx1) bx1 = shape_x[n];
         if (shape_y[n] < by0) by0 = shape_y[n];
         if (shape_y[n] > by1) by1 = shape_y[n];
      end
      k  = $urandom_range(shape_x.size() - 1);
      m  = (k + 1) % shape_x.size();
      px = rand_span(bx0, bx1);
      py = rand_span(by0, by1);
      case ($urandom_range(19))
         0, 1, 2: begin
            px = shape_x[k];
            py = shape_y[k];
         end
         3, 4, 5: py = shape_y[k];
         6, 7: begin
            px = (shape_x[k] + shape_x[m]) >>> 1;
            py = (shape_y[k] + shape_y[m]) >>> 1;
         end
         8: px = $urandom_range(1) ? bx0 - 1 : bx1 + 1;
         9: py = $urandom_range(1) ? by0 : by1;
         10: begin
            px = rand_span(COORD_MIN, COORD_MAX);
            py = rand_span(COORD_MIN, COORD_MAX);
         end
         11: begin
            add_item(ACT_NONE, rand_span(COORD_MIN, COORD_MAX), rand_span(COORD_MIN, COORD_MAX));
            return;
         end
         default: ;
      endcase
      add_item(ACT_QUERY, px, py);
   endfunction

   // an optional clear, a run of appends at one coordinate scale, then probes
   function automatic void add_polygon_set();
      int     n, q;
      longint lo, hi;
      if ($urandom_range(9) != 0)
         add_item(ACT_CLEAR, rand_span(COORD_MIN, COORD_MAX), rand_span(COORD_MIN, COORD_MAX));
      case ($urandom_range(9))
         0:       n = $urandom_range(2);
         1:       n = $urandom_range(19, 16);
         default: n = $urandom_range(16, 3);
      endcase
      case ($urandom_range(3))
         0: begin lo = -8;         hi = 8;         end
         1: begin lo = -(1 << 18); hi = 1 << 18;   end
         2: begin lo = -(1 << 26); hi = 1 << 26;   end
         default: begin lo = COORD_MIN; hi = COORD_MAX; end
      endcase
      repeat (n) add_item(ACT_APPEND, rand_span(lo, hi), rand_span(lo, hi));
      q = $urandom_range(8, 2);
      repeat (q) add_probe();
   endfunction

   initial begin
      int directed_count, phase, last_phase;

      // directed: empty store, full-range triangle, extremes, disabled zone, full store
      add_item(ACT_QUERY, 0, 0);
      add_item(ACT_APPEND, COORD_MIN, COORD_MIN);
      add_item(ACT_APPEND, COORD_MAX, COORD_MIN);
      add_item(ACT_APPEND, 0, COORD_MAX);
      add_item(ACT_QUERY, 0, 0);
      add_item(ACT_QUERY, COORD_MIN, COORD_MIN);
      add_item(ACT_QUERY, COORD_MAX - 1, COORD_MAX - 1);
      add_item(ACT_NONE, -1, -1);
      add_control(OP_ZONE_WRITE, 1'b0);
      add_item(ACT_QUERY, 0, 0);
      add_control(OP_ZONE_WRITE, 1'b1);
      for (int k = 0; k < 14; k++) add_item(ACT_APPEND, k * 7 - 40, 40 - k * 5);
      add_item(ACT_CLEAR, -1, -1);
      add_item(ACT_APPEND, 0, 0);
      add_item(ACT_APPEND, 100, 0);
      add_item(ACT_APPEND, 0, 100);
      add_item(ACT_QUERY, 200, 200);
      add_item(ACT_QUERY, 10, 10);
      directed_count = items_made;

      last_phase = -1;
      while (items_made < directed_count + RANDOM_ITEMS) begin
         phase = (items_made - directed_count) * 3 / RANDOM_ITEMS;
         if (phase != last_phase) begin
            case (phase)
               0:       sender_idle_pct = 32;
               1:       sender_idle_pct = 60;
               default: sender_idle_pct = 0;
            endcase
            add_control(OP_SETTLE, 1'b0);
            last_phase = phase;
         end
         if ($urandom_range(11) == 0) begin
            add_control(OP_ZONE_WRITE, 1'b0);
            add_polygon_set();
            add_control(OP_ZONE_WRITE, 1'b1);
         end else begin
            add_polygon_set();
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0) @(posedge clock);
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands; %0d answers checked: %0d inside, %0d full-store, %0d invalid.",
               items_made, answers_checked, inside_seen, full_seen, invalid_seen);
      $display("Zone enable written %0d times across three sender gap settings.", zone_writes);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

endmodule
